// File: rtl/mbpu_pkg.sv
// mbpu_pkg: shared types and constants for the msb-first bit packer/unpacker
// used by mbpu_ctrl, mbpu_store and msb_first_bit_packer_unpacker
`default_nettype none

package mbpu_pkg;

    // payload field widths
    localparam int ACTION_W = 3;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 6;
    localparam int STEP_W   = 16;
    localparam int INDEX_W  = 12;
    localparam int BYTE_W   = 8;
    localparam int USED_W   = 13;
    localparam int STATUS_W = 2;

    // store size default and field limit
    localparam int STORE_BYTES_DEF = 4096;
    localparam int MAX_FIELD_BITS  = 32;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PEEK      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STEP      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REWIND    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_BYTE = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // sequencer states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // sequencer controls toward the datapath
    typedef struct packed {
        logic in_ready;
        logic rd_en;
        logic done;
    } t_ctrl;

endpackage

`default_nettype wire

// File: rtl/mbpu_ctrl.sv
// mbpu_ctrl: two-state sequencer, memory read on accept, write back on finish
// depends on mbpu_pkg
`default_nettype none

module mbpu_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_busy,
    output mbpu_pkg::t_ctrl     o_ctrl
);
    import mbpu_pkg::*;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl = '0;
        case (r_state)
            S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.rd_en    = i_in_valid;
            end
            S_EXEC: begin
                o_ctrl.done = !i_out_busy;
            end
            default: o_ctrl = '0;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mbpu_store.sv
// mbpu_store: byte store as two 32-bit word banks (even and odd words)
// reads and writes a 64-bit window of two adjacent words; depends on mbpu_pkg
`default_nettype none

module mbpu_store #(
    parameter int STORE_BYTES = mbpu_pkg::STORE_BYTES_DEF,
    localparam int CAP_BITS   = STORE_BYTES * 8,
    localparam int PW         = $clog2(CAP_BITS + 1),
    localparam int WIW        = PW - 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [WIW-1:0]    i_rd_word,
    output logic      [63:0]       o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [WIW-1:0]    i_wr_word,
    input  wire logic [63:0]       i_wr_data
);
    import mbpu_pkg::*;

    localparam int WORDS = (STORE_BYTES + 3) / 4;
    localparam int DEPTH = (WORDS + 1) / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] r_bank_e [DEPTH];
    logic [31:0] r_bank_o [DEPTH];
    logic [31:0] r_rd_e;
    logic [31:0] r_rd_o;
    logic        r_swap;

    logic [WIW:0]  rd_w0, rd_w1, rd_even, rd_odd;
    logic [WIW:0]  wr_w0, wr_w1, wr_even, wr_odd;
    logic [AW-1:0] rd_addr_e, rd_addr_o, wr_addr_e, wr_addr_o;
    logic          rd_ok_e, rd_ok_o, wr_ok_e, wr_ok_o;
    logic [31:0]   wr_data_e, wr_data_o;

    // split a window into its even and odd word
    always_comb begin
        rd_w0     = {1'b0, i_rd_word};
        rd_w1     = rd_w0 + 1'b1;
        rd_even   = rd_w0[0] ? rd_w1 : rd_w0;
        rd_odd    = rd_w0[0] ? rd_w0 : rd_w1;
        rd_ok_e   = 32'(rd_even) < 32'(WORDS);
        rd_ok_o   = 32'(rd_odd) < 32'(WORDS);
        rd_addr_e = AW'(rd_even >> 1);
        rd_addr_o = AW'(rd_odd >> 1);

        wr_w0     = {1'b0, i_wr_word};
        wr_w1     = wr_w0 + 1'b1;
        wr_even   = wr_w0[0] ? wr_w1 : wr_w0;
        wr_odd    = wr_w0[0] ? wr_w0 : wr_w1;
        wr_ok_e   = 32'(wr_even) < 32'(WORDS);
        wr_ok_o   = 32'(wr_odd) < 32'(WORDS);
        wr_addr_e = AW'(wr_even >> 1);
        wr_addr_o = AW'(wr_odd >> 1);
        wr_data_e = wr_w0[0] ? i_wr_data[31:0] : i_wr_data[63:32];
        wr_data_o = wr_w0[0] ? i_wr_data[63:32] : i_wr_data[31:0];
    end

    // even bank
    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_ok_e) begin
            r_bank_e[wr_addr_e] <= wr_data_e;
        end
        if (i_rd_en && rd_ok_e) begin
            r_rd_e <= r_bank_e[rd_addr_e];
        end
    end

    // odd bank
    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_ok_o) begin
            r_bank_o[wr_addr_o] <= wr_data_o;
        end
        if (i_rd_en && rd_ok_o) begin
            r_rd_o <= r_bank_o[rd_addr_o];
        end
    end

    // word order of the read window
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_swap <= rd_w0[0];
        end
    end

    assign o_rd_data = r_swap ? {r_rd_o, r_rd_e} : {r_rd_e, r_rd_o};

endmodule

`default_nettype wire

// File: rtl/msb_first_bit_packer_unpacker.sv
// msb_first_bit_packer_unpacker: msb-first bit writer/reader over a byte store
// the store is read when an item is accepted and written back when its result is
// registered; no new item is accepted until the last one is done
// reset: positions go to zero; store bits at or past the write position read
// as zero, so no clearing pass is needed; depends on mbpu_pkg, mbpu_ctrl, mbpu_store
`default_nettype none

module msb_first_bit_packer_unpacker #(
    parameter int STORE_BYTES = mbpu_pkg::STORE_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [mbpu_pkg::ACTION_W-1:0]   i_action,
    input  wire logic [mbpu_pkg::DATA_W-1:0]     i_value,
    input  wire logic [mbpu_pkg::COUNT_W-1:0]    i_bit_count,
    input  wire logic [mbpu_pkg::STEP_W-1:0]     i_step_bits,
    input  wire logic [mbpu_pkg::INDEX_W-1:0]    i_byte_index,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [mbpu_pkg::DATA_W-1:0]     o_peek_data,
    output logic      [mbpu_pkg::BYTE_W-1:0]     o_byte_data,
    output logic      [mbpu_pkg::USED_W-1:0]     o_used_bytes,
    output logic      [mbpu_pkg::STATUS_W-1:0]   o_status
);
    import mbpu_pkg::*;

    localparam int CAP_BITS = STORE_BYTES * 8;
    localparam int PW       = $clog2(CAP_BITS + 1);
    localparam int WIW      = PW - 5;

    t_ctrl ctrl;

    // positions and latched item
    logic [PW-1:0]       r_wp, r_rp, n_wp, n_rp;
    logic [ACTION_W-1:0] r_action;
    logic [DATA_W-1:0]   r_value;
    logic [COUNT_W-1:0]  r_count;
    logic [STEP_W-1:0]   r_step;
    logic [INDEX_W-1:0]  r_index;

    // result register
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_peek;
    logic [BYTE_W-1:0]   r_byte;
    logic [USED_W-1:0]   r_used;
    logic [STATUS_W-1:0] r_status;

    logic [WIW-1:0]      rd_word, wr_word;
    logic [63:0]         win, wr_data;
    logic                wr_en;

    logic                count_ok, full;
    logic [31:0]         room_w, room_r, rp_step, avail, base, avail_b, used32;
    logic [5:0]          amin;
    logic [3:0]          bmin;
    logic [31:0]         top, vmask, peek_val, field, bword;
    logic [63:0]         ins, keep;
    logic [7:0]          bmask, byte_val;
    logic [DATA_W-1:0]   res_peek;
    logic [BYTE_W-1:0]   res_byte;
    logic [STATUS_W-1:0] res_status;

    mbpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (r_out_valid && !i_out_ready),
        .o_ctrl     (ctrl)
    );

    // read window address from the incoming item
    always_comb begin
        case (i_action)
            ACT_PUSH:      rd_word = WIW'(r_wp >> 5);
            ACT_PEEK:      rd_word = WIW'(r_rp >> 5);
            default:       rd_word = WIW'(32'(i_byte_index) >> 2);
        endcase
    end

    assign wr_word = WIW'(r_wp >> 5);

    mbpu_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (ctrl.rd_en),
        .i_rd_word (rd_word),
        .o_rd_data (win),
        .i_wr_en   (wr_en),
        .i_wr_word (wr_word),
        .i_wr_data (wr_data)
    );

    // push: merge the field behind the written bits of the window
    always_comb begin
        count_ok = (r_count >= COUNT_W'(1)) && (32'(r_count) <= 32'(MAX_FIELD_BITS));
        room_w   = 32'(CAP_BITS) - 32'(r_wp);
        full     = room_w < 32'(r_count);
        field    = r_value << (6'd32 - r_count);
        ins      = {field, 32'h0} >> r_wp[4:0];
        keep     = ~(64'hFFFF_FFFF_FFFF_FFFF >> r_wp[4:0]);
        wr_data  = (win & keep) | ins;
    end

    // peek: align window at the reader, zero bits past the writer
    always_comb begin
        top      = 32'((win << r_rp[4:0]) >> 32);
        avail    = (r_wp > r_rp) ? 32'(r_wp - r_rp) : 32'h0;
        amin     = (avail > 32'd32) ? 6'd32 : avail[5:0];
        vmask    = ~(32'hFFFF_FFFF >> amin);
        peek_val = (top & vmask) >> (6'd32 - r_count);
    end

    // step: saturate the reader at capacity
    always_comb begin
        room_r  = 32'(CAP_BITS) - 32'(r_rp);
        rp_step = (room_r < 32'(r_step)) ? 32'(CAP_BITS) : 32'(r_rp) + 32'(r_step);
    end

    // read byte: pick the byte, zero bits past the writer
    always_comb begin
        bword    = win[63:32] >> {~r_index[1:0], 3'b000};
        base     = 32'(r_index) << 3;
        avail_b  = (32'(r_wp) > base) ? 32'(r_wp) - base : 32'h0;
        bmin     = (avail_b > 32'd8) ? 4'd8 : avail_b[3:0];
        bmask    = ~(8'hFF >> bmin);
        byte_val = (32'(r_index) < 32'(STORE_BYTES)) ? (bword[7:0] & bmask) : 8'h0;
    end

    // action decode
    always_comb begin
        n_wp       = r_wp;
        n_rp       = r_rp;
        res_peek   = '0;
        res_byte   = '0;
        res_status = ST_OK;
        wr_en      = 1'b0;
        case (r_action)
            ACT_PUSH: begin
                if (!count_ok) begin
                    res_status = ST_BAD_COUNT;
                end else if (full) begin
                    res_status = ST_FULL;
                end else begin
                    wr_en = ctrl.done;
                    n_wp  = r_wp + PW'(r_count);
                end
            end
            ACT_PEEK: begin
                if (!count_ok) begin
                    res_status = ST_BAD_COUNT;
                end else begin
                    res_peek = peek_val;
                end
            end
            ACT_STEP:      n_rp = PW'(rp_step);
            ACT_REWIND:    n_rp = '0;
            ACT_READ_BYTE: res_byte = byte_val;
            default: begin
            end
        endcase
        used32 = (32'(n_wp) + 32'd7) >> 3;
    end

    // positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else if (ctrl.done) begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    // latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_in_valid && ctrl.in_ready) begin
            r_action <= i_action;
            r_value  <= i_value;
            r_count  <= i_bit_count;
            r_step   <= i_step_bits;
            r_index  <= i_byte_index;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (ctrl.done) begin
            r_peek   <= res_peek;
            r_byte   <= res_byte;
            r_used   <= used32[USED_W-1:0];
            r_status <= res_status;
        end
    end

    assign o_in_ready   = ctrl.in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_peek_data  = r_peek;
    assign o_byte_data  = r_byte;
    assign o_used_bytes = r_used;
    assign o_status     = r_status;

endmodule

`default_nettype wire

// File: sim/msb_first_bit_packer_unpacker_test.sv
// msb_first_bit_packer_unpacker_test: self-checking bench for the msb-first bit writer/reader,
// random handshake stalls on both sides, an in-bench model of store and positions
// depends on mbpu_pkg and msb_first_bit_packer_unpacker
`default_nettype none

module msb_first_bit_packer_unpacker_test;
    import mbpu_pkg::*;

    localparam int STORE_BYTES = STORE_BYTES_DEF;
    localparam int CAP_BITS    = STORE_BYTES * 8;
    localparam int MIX_ITEMS   = 600;
    localparam int TAIL_ITEMS  = 120;
    localparam int QUIET_TAIL  = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 400;
    localparam int CYCLE_LIMIT = 400000;

    // highest action code; codes above read byte do nothing
    localparam logic [ACTION_W-1:0] ACT_LAST = '1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0]   value;
        logic [COUNT_W-1:0]  bit_count;
        logic [STEP_W-1:0]   step_bits;
        logic [INDEX_W-1:0]  byte_index;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0]   peek_data;
        logic [BYTE_W-1:0]   byte_data;
        logic [USED_W-1:0]   used_bytes;
        logic [STATUS_W-1:0] status;
    } t_result;

    // block inputs, known from time zero
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                i_out_ready  = 1'b0;
    logic [ACTION_W-1:0] i_action     = '0;
    logic [DATA_W-1:0]   i_value      = '0;
    logic [COUNT_W-1:0]  i_bit_count  = '0;
    logic [STEP_W-1:0]   i_step_bits  = '0;
    logic [INDEX_W-1:0]  i_byte_index = '0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic [DATA_W-1:0]   o_peek_data;
    logic [BYTE_W-1:0]   o_byte_data;
    logic [USED_W-1:0]   o_used_bytes;
    logic [STATUS_W-1:0] o_status;

    msb_first_bit_packer_unpacker #(
        .STORE_BYTES(STORE_BYTES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_bit_count (i_bit_count),
        .i_step_bits (i_step_bits),
        .i_byte_index(i_byte_index),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_peek_data (o_peek_data),
        .o_byte_data (o_byte_data),
        .o_used_bytes(o_used_bytes),
        .o_status    (o_status)
    );

    // model of the store and both bit positions
    logic [BYTE_W-1:0] store_model [STORE_BYTES];
    int unsigned       wr_bit;
    int unsigned       rd_bit;

    // stimulus bookkeeping: writer and reader as the generator expects them
    int                gen_wr;
    int                gen_rd;

    t_item   pending_items[$];
    t_result predicted_results[$];
    t_item   cur_item;

    int  total_items   = 0;
    int  n_accepted    = 0;
    int  n_checked     = 0;
    int  n_dropped     = 0;
    int  n_bad_count   = 0;
    int  mismatches    = 0;
    int  in_gap        = 0;
    int  out_stall     = 0;
    int  hold_left     = 0;
    int  holds_done    = 0;
    int  cycle_count   = 0;
    bit  in_taken      = 1'b0;
    bit  in_gappy      = 1'b1;
    bit  out_gappy     = 1'b1;
    bit  quiet_tail    = 1'b0;

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit stored_bit(input int unsigned pos);
        if (pos >= CAP_BITS || pos >= wr_bit)
            return 1'b0;
        return store_model[pos >> 3][7 - (pos & 7)];
    endfunction

    // advance the model by one item and return the result it must produce
    function automatic t_result apply_item(input t_item it);
        t_result     r;
        int unsigned n;
        int unsigned pos;
        int unsigned i;
        r = '0;
        n = it.bit_count;
        case (it.action)
            ACT_PUSH: begin
                if (n < 1 || n > MAX_FIELD_BITS) begin
                    r.status = ST_BAD_COUNT;
                    n_bad_count++;
                end else if (CAP_BITS - wr_bit < n) begin
                    r.status = ST_FULL;
                    n_dropped++;
                end else begin
                    for (i = 0; i < n; i++) begin
                        pos = wr_bit + i;
                        if (it.value[n - 1 - i])
                            store_model[pos >> 3] = store_model[pos >> 3] | (8'h80 >> (pos & 7));
                    end
                    wr_bit += n;
                end
            end
            ACT_PEEK: begin
                if (n < 1 || n > MAX_FIELD_BITS) begin
                    r.status = ST_BAD_COUNT;
                    n_bad_count++;
                end else begin
                    for (i = 0; i < n; i++)
                        r.peek_data = {r.peek_data[DATA_W-2:0], stored_bit(rd_bit + i)};
                end
            end
            ACT_STEP: begin
                if (CAP_BITS - rd_bit < it.step_bits)
                    rd_bit = CAP_BITS;
                else
                    rd_bit += it.step_bits;
            end
            ACT_REWIND: begin
                rd_bit = 0;
            end
            ACT_READ_BYTE: begin
                if (it.byte_index < STORE_BYTES)
                    r.byte_data = store_model[it.byte_index];
            end
            default: begin
            end
        endcase
        r.used_bytes = USED_W'((wr_bit + 7) >> 3);
        return r;
    endfunction

    // append one item and track where writer and reader will stand
    task automatic queue_item(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] val,
                              input int cnt, input int stp, input int idx);
        t_item it;
        it.action     = act;
        it.value      = val;
        it.bit_count  = COUNT_W'(cnt);
        it.step_bits  = STEP_W'(stp);
        it.byte_index = INDEX_W'(idx);
        pending_items.push_back(it);
        if (act == ACT_PUSH && cnt >= 1 && cnt <= MAX_FIELD_BITS && CAP_BITS - gen_wr >= cnt)
            gen_wr += cnt;
        if (act == ACT_STEP)
            gen_rd = (CAP_BITS - gen_rd < it.step_bits) ? CAP_BITS : gen_rd + it.step_bits;
        if (act == ACT_REWIND)
            gen_rd = 0;
    endtask

    // one random item; filling pushes long fields and tends to land on the store end
    task automatic queue_random(input int push_pct, input bit filling);
        int                  roll;
        int                  cnt;
        int                  stp;
        int                  idx;
        int                  room;
        int                  used;
        int                  target;
        logic [ACTION_W-1:0] act;
        roll = $urandom_range(0, 99);
        cnt  = $urandom_range(0, 63);
        stp  = $urandom_range(0, 65535);
        idx  = $urandom_range(0, STORE_BYTES - 1);
        room = CAP_BITS - gen_wr;
        used = (gen_wr + 7) >> 3;
        if (roll < push_pct) begin
            act = ACT_PUSH;
            if ($urandom_range(0, 99) < 5) begin
                cnt = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_FIELD_BITS + 1, 63);
            end else if (filling) begin
                cnt = $urandom_range(24, MAX_FIELD_BITS);
                if (cnt > room && room > 0 && $urandom_range(0, 1))
                    cnt = room;
            end else begin
                cnt = $urandom_range(1, MAX_FIELD_BITS);
            end
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                act = ACT_PEEK;
                if ($urandom_range(0, 99) < 5)
                    cnt = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_FIELD_BITS + 1, 63);
                else
                    cnt = $urandom_range(1, MAX_FIELD_BITS);
            end else if (roll < 65) begin
                act  = ACT_STEP;
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    stp = $urandom_range(0, 40);
                end else if (roll < 70) begin
                    // bring the reader close to the writer
                    target = gen_wr + $urandom_range(0, 64) - 32;
                    stp = (target > gen_rd) ? target - gen_rd : $urandom_range(0, 8);
                end else if (roll < 90) begin
                    stp = $urandom_range(0, 1000);
                end
            end else if (roll < 70) begin
                act = ACT_REWIND;
            end else if (roll < 92) begin
                act  = ACT_READ_BYTE;
                roll = $urandom_range(0, 99);
                if (roll < 70 && used > 0)
                    idx = $urandom_range(0, used - 1);
                else if (roll < 80)
                    idx = $urandom_range(STORE_BYTES - 8, STORE_BYTES - 1);
            end else begin
                act = ACTION_W'($urandom_range(ACT_READ_BYTE + 1, ACT_LAST));
            end
        end
        queue_item(act, $urandom(), cnt, stp, idx);
    endtask

    // record accepted items and predict their results
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        if (in_taken) begin
            predicted_results.push_back(apply_item(cur_item));
            n_accepted++;
            if ($urandom_range(0, 99) < 3)
                in_gappy = !in_gappy;
        end
    end

    // item driver, fed from the pending queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (in_taken || !i_in_valid) begin
            if (in_taken && !quiet_tail && in_gappy && $urandom_range(0, 99) < 30)
                in_gap = $urandom_range(1, 9);
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                cur_item = pending_items.pop_front();
                i_in_valid   <= 1'b1;
                i_action     <= cur_item.action;
                i_value      <= cur_item.value;
                i_bit_count  <= cur_item.bit_count;
                i_step_bits  <= cur_item.step_bits;
                i_byte_index <= cur_item.byte_index;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-offs while the sender keeps offering items
    always @(posedge i_clk) begin
        quiet_tail = pending_items.size() < QUIET_TAIL;
        if (hold_left != 0) begin
            hold_left--;
        end else if (i_rst_n && holds_done < 2 &&
                     pending_items.size() <= total_items - HOLD_AFTER * (holds_done + 1)) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
    end

    // result ready with random stall bursts
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
        end else if (out_stall != 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else if (!quiet_tail && out_gappy && $urandom_range(0, 99) < 20) begin
            out_stall = $urandom_range(1, 9) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string label, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_results.size() == 0) begin
                $display("%0t: result with no item outstanding, expected none, got %0h %0h %0h %0h",
                         $time, o_peek_data, o_byte_data, o_used_bytes, o_status);
                mismatches++;
            end else begin
                want = predicted_results.pop_front();
                check_field("peek_data", want.peek_data, o_peek_data);
                check_field("byte_data", DATA_W'(want.byte_data), DATA_W'(o_byte_data));
                check_field("used_bytes", DATA_W'(want.used_bytes), DATA_W'(o_used_bytes));
                check_field("status", DATA_W'(want.status), DATA_W'(o_status));
                n_checked++;
            end
            if ($urandom_range(0, 99) < 3)
                out_gappy = !out_gappy;
        end
    end

    // run limit
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge i_clk);
        $display("%0t: timeout with %0d items pending and %0d results outstanding",
                 $time, pending_items.size(), predicted_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        for (int b = 0; b < STORE_BYTES; b++)
            store_model[b] = '0;
        wr_bit = 0;
        rd_bit = 0;
        gen_wr = 0;
        gen_rd = 0;

        // directed: empty store, bad counts, word spanning five bytes, reader past the end
        queue_item(ACT_READ_BYTE, '1, 0, 0, 0);
        queue_item(ACT_PEEK, '0, MAX_FIELD_BITS, 0, 0);
        queue_item(ACT_PUSH, '1, 0, 0, 0);
        queue_item(ACT_PUSH, '1, 63, 65535, STORE_BYTES - 1);
        queue_item(ACT_PUSH, '1, MAX_FIELD_BITS + 1, 0, 0);
        queue_item(ACT_PEEK, '1, 0, 0, 0);
        queue_item(ACT_PEEK, '1, 63, 0, 0);
        queue_item(ACT_PUSH, 32'h0000_0001, 1, 0, 0);
        queue_item(ACT_PUSH, 32'hFFFF_FFFF, MAX_FIELD_BITS, 0, 0);
        queue_item(ACT_PUSH, 32'hA5A5_A5D5, 7, 0, 0);
        queue_item(ACT_PUSH, 32'h8000_0001, MAX_FIELD_BITS, 0, 0);
        queue_item(ACT_READ_BYTE, '0, 0, 0, 4);
        queue_item(ACT_PEEK, '0, MAX_FIELD_BITS, 0, 0);
        queue_item(ACT_PEEK, '0, 1, 0, 0);
        queue_item(ACT_STEP, '0, 0, 3, 0);
        queue_item(ACT_PEEK, '0, MAX_FIELD_BITS, 0, 0);
        queue_item(ACT_STEP, '0, 0, 50, 0);
        queue_item(ACT_PEEK, '1, MAX_FIELD_BITS, 0, 0);
        queue_item(ACT_READ_BYTE, '0, 0, 0, STORE_BYTES - 1);
        queue_item(ACT_LAST, '1, 63, 65535, STORE_BYTES - 1);
        queue_item(ACTION_W'(ACT_READ_BYTE + 1), '1, 63, 65535, STORE_BYTES - 1);
        queue_item(ACT_STEP, '0, 0, 65535, 0);
        queue_item(ACT_PEEK, '0, MAX_FIELD_BITS, 0, 0);
        queue_item(ACT_STEP, '0, 0, 0, 0);
        queue_item(ACT_REWIND, '1, 63, 65535, STORE_BYTES - 1);
        queue_item(ACT_STEP, '0, 0, CAP_BITS, 0);
        queue_item(ACT_REWIND, '0, 0, 0, 0);
        queue_item(ACT_PEEK, '0, 16, 0, 0);

        // random: mixed traffic, then fill the store to the end, then run on it full
        repeat (MIX_ITEMS)
            queue_random(50, 1'b0);
        while (gen_wr < CAP_BITS)
            queue_random(85, 1'b1);
        repeat (TAIL_ITEMS)
            queue_random(40, 1'b0);
        total_items = pending_items.size();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d results of %0d items; %0d pushes dropped on a full store,",
                 n_checked, n_accepted, n_dropped);
        $display("%0d bad bit counts, %0d of %0d store bytes written, %0d receiver hold-offs",
                 n_bad_count, (wr_bit + 7) >> 3, STORE_BYTES, holds_done);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/mbpu_pkg.sv
rtl/mbpu_ctrl.sv
rtl/mbpu_store.sv
rtl/msb_first_bit_packer_unpacker.sv
sim/msb_first_bit_packer_unpacker_test.sv
